@@ hw/rtl/ptt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and widths for the periodic / one-shot timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int KIND_W         = 3;
  localparam int TIME_W         = 32;
  localparam int SLOT_W         = 6;
  localparam int RES_W          = 2;
  localparam int SLOT_COUNT_DEF = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SCAN         = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REG_PERIODIC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REG_ONCE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ENABLE       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DISABLE      = 3'd5;

  // Result kinds
  localparam logic [RES_W-1:0] RES_FIRED      = 2'd0;
  localparam logic [RES_W-1:0] RES_REGISTERED = 2'd1;
  localparam logic [RES_W-1:0] RES_FULL       = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } ptt_state_t;

  // One table entry as held in the slot RAM
  typedef struct packed {
    logic              occ;
    logic              en;
    logic              one_shot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] last_time;
  } slot_ent_t;

endpackage

@@ hw/rtl/ptt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_in_if / ptt_out_if
// Valid/ready channels for timer table items and results.
// ----------------------------------------------------------------------------
interface ptt_in_if
  import ptt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] interval_ms;
  logic [SLOT_W-1:0] slot_id;

  modport source (output valid, kind, now_ms, interval_ms, slot_id, input ready);
  modport sink   (input valid, kind, now_ms, interval_ms, slot_id, output ready);
endinterface

interface ptt_out_if
  import ptt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [RES_W-1:0]  result_kind;
  logic [SLOT_W-1:0] slot;
  logic              last;

  modport source (output valid, result_kind, slot, last, input ready);
  modport sink   (input valid, result_kind, slot, last, output ready);
endinterface

@@ hw/rtl/ptt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/periodic_oneshot_timer_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_table
// Table of timer slots held in one RAM, walked by a read-modify-write
// sequencer for scan, register, enable and disable transactions.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Payload
//  --------  ---  ---------------  -----------------------------------------
//  in_chan   in   valid / ready    kind, now_ms, interval_ms, slot_id
//  out_chan  out  valid / ready    result_kind, slot, last
//
//  One item at a time. Scan and register walk the slot RAM one slot per
//  cycle unless the output stalls (one read port, registered read data);
//  register stops once a slot is taken. Enable and disable rewrite one
//  slot; remove, out-of-range ids and unused kinds finish at acceptance.
//  Reset: synchronous, active low; per-slot valid flops clear at once, so a
//  slot never written since reset or remove reads as all zero. No sweep.
//  Stalls: results go through a one-deep output register; a back-pressured
//  output freezes the walk at the slot being evaluated.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_table
  import ptt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptt_in_if.sink     in_chan,
  ptt_out_if.source  out_chan
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int ENT_W = $bits(slot_ent_t);
  localparam logic [SLOT_W:0] SLOT_LIM = (SLOT_W + 1)'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);

  // Sequencer state
  ptt_state_t         state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  period_r;
  logic [CNT_W-1:0]   ctr_r;       // next slot to read
  logic [CNT_W-1:0]   end_r;       // one past the last slot of the walk
  logic               ev_vld_r;    // read data for ev_addr_r is present
  logic [IDX_W-1:0]   ev_addr_r;
  logic               found_r;     // register: slot already taken
  logic               pend_vld_r;  // scan: a firing held back for its last flag
  logic [IDX_W-1:0]   pend_slot_r;
  logic [SLOT_COUNT-1:0] val_r;    // entry written since reset / remove

  // Output register
  logic               out_vld_r;
  logic [RES_W-1:0]   out_kind_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_last_r;

  // RAM
  logic [ENT_W-1:0]   ram_q;
  slot_ent_t          ent;
  slot_ent_t          wdata;
  logic               wr;

  // Control
  logic               in_acc;
  logic               id_ok;
  logic               out_free;
  logic [TIME_W-1:0]  elapsed;
  logic               due;
  logic               free_slot;
  logic               stall;
  logic               issue;
  logic               push;
  logic [RES_W-1:0]   push_kind;
  logic [SLOT_W-1:0]  push_slot;
  logic               push_last;
  logic               pend_ld;
  logic               pend_clr;
  logic               val_set;
  logic               val_clr;
  logic               found_set;
  logic               fin_done;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign id_ok         = {1'b0, in_chan.slot_id} < SLOT_LIM;
  assign out_free      = !out_vld_r || out_chan.ready;

  // An entry never written since reset or remove reads as zero.
  assign ent       = val_r[ev_addr_r] ? slot_ent_t'(ram_q) : slot_ent_t'('0);
  assign elapsed   = now_r - ent.last_time;   // wraps modulo 2^32
  assign due       = ent.en && ent.occ && (elapsed > ent.period);
  assign free_slot = !ent.en && !ent.occ;

  // --------------------------------------------------------------------------
  // Datapath control (FSM outputs)
  // --------------------------------------------------------------------------
  always_comb begin
    stall     = 1'b0;
    push      = 1'b0;
    push_kind = RES_FIRED;
    push_slot = '0;
    push_last = 1'b0;
    pend_ld   = 1'b0;
    pend_clr  = 1'b0;
    val_set   = 1'b0;
    val_clr   = 1'b0;
    found_set = 1'b0;
    fin_done  = 1'b0;
    wr        = 1'b0;
    wdata     = ent;

    if (state_r == ST_RUN && ev_vld_r) begin
      unique case (kind_r) inside
        KIND_SCAN: begin
          if (due) begin
            if (pend_vld_r && !out_free) begin
              stall = 1'b1;
            end else begin
              // Earlier firing goes out now: it is not the final one.
              push      = pend_vld_r;
              push_kind = RES_FIRED;
              push_slot = SLOT_W'(pend_slot_r);
              push_last = 1'b0;
              pend_ld   = 1'b1;
              if (ent.one_shot) begin
                val_clr = 1'b1;
              end else begin
                wr              = 1'b1;
                wdata.last_time = now_r;
              end
            end
          end
        end
        KIND_REG_PERIODIC, KIND_REG_ONCE: begin
          if (!found_r && free_slot) begin
            if (!out_free) begin
              stall = 1'b1;
            end else begin
              push            = 1'b1;
              push_kind       = RES_REGISTERED;
              push_slot       = SLOT_W'(ev_addr_r);
              push_last       = 1'b1;
              found_set       = 1'b1;
              val_set         = 1'b1;
              wr              = 1'b1;
              wdata.occ       = 1'b1;
              wdata.en        = 1'b1;
              wdata.one_shot  = (kind_r == KIND_REG_ONCE);
              wdata.period    = period_r;
              wdata.last_time = now_r;
            end
          end
        end
        KIND_ENABLE: begin
          wr              = 1'b1;
          val_set         = 1'b1;
          wdata.en        = 1'b1;
          wdata.last_time = now_r;
        end
        KIND_DISABLE: begin
          wr       = 1'b1;
          val_set  = 1'b1;
          wdata.en = 1'b0;
        end
        default: ;
      endcase
    end

    if (state_r == ST_FIN) begin
      unique case (kind_r) inside
        KIND_SCAN: begin
          if (!pend_vld_r) begin
            fin_done = 1'b1;
          end else if (out_free) begin
            push      = 1'b1;
            push_kind = RES_FIRED;
            push_slot = SLOT_W'(pend_slot_r);
            push_last = 1'b1;
            pend_clr  = 1'b1;
            fin_done  = 1'b1;
          end
        end
        KIND_REG_PERIODIC, KIND_REG_ONCE: begin
          if (found_r) begin
            fin_done = 1'b1;
          end else if (out_free) begin
            push      = 1'b1;
            push_kind = RES_FULL;
            push_slot = '0;
            push_last = 1'b1;
            fin_done  = 1'b1;
          end
        end
        default: fin_done = 1'b1;
      endcase
    end
  end

  // Register walk stops issuing once a slot has been taken.
  assign issue = (state_r == ST_RUN) && !stall && (ctr_r < end_r) &&
                 !(found_r || found_set);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_chan.kind) inside
            KIND_SCAN, KIND_REG_PERIODIC, KIND_REG_ONCE: state_nxt = ST_RUN;
            KIND_ENABLE, KIND_DISABLE: state_nxt = id_ok ? ST_RUN : ST_IDLE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (!stall && !issue) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ev_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      val_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (in_acc) begin
        found_r    <= 1'b0;
        pend_vld_r <= 1'b0;
        if (in_chan.kind == KIND_REMOVE && id_ok) begin
          val_r[in_chan.slot_id[IDX_W-1:0]] <= 1'b0;
        end
      end else begin
        if (found_set) begin
          found_r <= 1'b1;
        end
        if (pend_ld) begin
          pend_vld_r <= 1'b1;
        end else if (pend_clr) begin
          pend_vld_r <= 1'b0;
        end
        if (val_set) begin
          val_r[ev_addr_r] <= 1'b1;
        end else if (val_clr) begin
          val_r[ev_addr_r] <= 1'b0;
        end
      end

      if (!stall) begin
        ev_vld_r <= issue;
      end

      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= in_chan.kind;
      now_r    <= in_chan.now_ms;
      period_r <= in_chan.interval_ms;
      if (in_chan.kind == KIND_ENABLE || in_chan.kind == KIND_DISABLE) begin
        ctr_r <= CNT_W'(in_chan.slot_id);
        end_r <= CNT_W'({1'b0, in_chan.slot_id} + 7'd1);
      end else begin
        ctr_r <= '0;
        end_r <= CNT_END;
      end
    end else if (issue) begin
      ctr_r <= ctr_r + 1'b1;
    end

    if (!stall && issue) begin
      ev_addr_r <= ctr_r[IDX_W-1:0];
    end

    if (pend_ld) begin
      pend_slot_r <= ev_addr_r;
    end

    if (push) begin
      out_kind_r <= push_kind;
      out_slot_r <= push_slot;
      out_last_r <= push_last;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.slot        = out_slot_r;
  assign out_chan.last        = out_last_r;

  // --------------------------------------------------------------------------
  // Slot RAM: one entry per slot
  // --------------------------------------------------------------------------
  ptt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (ev_addr_r),
    .wdata (wdata),
    .re    (issue),
    .raddr (ctr_r[IDX_W-1:0]),
    .rdata (ram_q)
  );

endmodule

@@ hw/rtl/ptt_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_chk
// Port-level checks for the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_chk
  import ptt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [KIND_W-1:0] in_kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic [RES_W-1:0]  out_result_kind,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_last
);

  localparam logic [SLOT_W:0] SLOT_LIM = (SLOT_W + 1)'(SLOT_COUNT);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
                                $stable(out_slot) && $stable(out_last))
    else $error("result changed while stalled");

  // A scan always walks the table, so input is closed the next cycle
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_SCAN |=> !in_ready)
    else $error("scan did not occupy the sequencer");

  // Register outcomes are single results
  a_reg_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RES_REGISTERED || out_result_kind == RES_FULL)
      |-> out_last)
    else $error("register result without last");

  // Full carries slot 0; other slots stay inside the table
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == RES_FULL && out_slot == '0) ||
                  ((out_result_kind == RES_FIRED || out_result_kind == RES_REGISTERED) &&
                   {1'b0, out_slot} < SLOT_LIM))
    else $error("bad result kind or slot");

endmodule

bind periodic_oneshot_timer_table ptt_chk #(
  .SLOT_COUNT (SLOT_COUNT)
) u_ptt_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_kind         (in_chan.kind),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_result_kind (out_chan.result_kind),
  .out_slot        (out_chan.slot),
  .out_last        (out_chan.last)
);

@@ sim/tb_periodic_oneshot_timer_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_oneshot_timer_table
// Self-checking bench for the periodic / one-shot timer table: a directed
// walk through reset, full-table, wrap and out-of-range cases, then random
// register / scan / remove / enable / disable traffic. Expected notices come
// from a local copy of the slot table, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb_periodic_oneshot_timer_table;
  import ptt_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int LIVE_ITEMS = 248;
  // Worst quiet stretch: a sender gap + one walk of the RAM + the longest
  // sink stall. Anything near this limit is a hang.
  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4 * SLOTS;

  // Kinds the block must swallow without a transaction on the output
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] interval_ms;
    logic [SLOT_W-1:0] slot_id;
  } timer_item_t;

  typedef struct {
    logic [RES_W-1:0]  result_kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } notice_t;

  // One line of the directed walk; want is only used when pinned is set
  typedef struct {
    timer_item_t item;
    int unsigned reps;
    bit          pinned;
    notice_t     want;
  } walk_row_t;

  typedef enum int unsigned {
    RX_FLOW,
    RX_COIN,
    RX_COMB,
    RX_LONG
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  ptt_in_if  in_bus ();
  ptt_out_if out_bus ();

  periodic_oneshot_timer_table #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always #5ns clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow timer table
  // --------------------------------------------------------------------------
  bit                tm_occ    [SLOTS];
  bit                tm_en     [SLOTS];
  bit                tm_once   [SLOTS];
  logic [TIME_W-1:0] tm_period [SLOTS];
  logic [TIME_W-1:0] tm_stamp  [SLOTS];

  notice_t   fresh_q[$];   // notices raised by the item just accepted
  notice_t   notice_q[$];  // notices owed by the block, oldest first
  walk_row_t walk_q[$];

  int unsigned err_count   = 0;
  int unsigned stuck_cycles = 0;
  int unsigned burst_left  = 0;

  function automatic void clear_timer_slot(int s);
    tm_occ[s]    = 1'b0;
    tm_en[s]     = 1'b0;
    tm_once[s]   = 1'b0;
    tm_period[s] = '0;
    tm_stamp[s]  = '0;
  endfunction

  // Advance the shadow table by one item and collect the notices it raises
  function automatic void apply_timer_item(timer_item_t it);
    logic [TIME_W-1:0] elapsed;
    notice_t           n;
    bit                id_ok;
    int                s;
    fresh_q.delete();
    id_ok = it.slot_id < SLOTS;
    case (it.kind)
      KIND_SCAN: begin
        for (s = 0; s < SLOTS; s++) begin
          elapsed = it.now_ms - tm_stamp[s];  // wraps modulo 2^32
          if (tm_en[s] && tm_occ[s] && elapsed > tm_period[s]) begin
            tm_stamp[s] = it.now_ms;
            n = '{RES_FIRED, SLOT_W'(s), 1'b0};
            fresh_q.push_back(n);
            if (tm_once[s]) clear_timer_slot(s);
          end
        end
        if (fresh_q.size() > 0) fresh_q[fresh_q.size() - 1].last = 1'b1;
      end
      KIND_REG_PERIODIC, KIND_REG_ONCE: begin
        n = '{RES_FULL, '0, 1'b1};
        for (s = 0; s < SLOTS; s++) begin
          if (n.result_kind == RES_FULL && !tm_en[s] && !tm_occ[s]) begin
            tm_occ[s]    = 1'b1;
            tm_en[s]     = 1'b1;
            tm_once[s]   = (it.kind == KIND_REG_ONCE);
            tm_period[s] = it.interval_ms;
            tm_stamp[s]  = it.now_ms;
            n = '{RES_REGISTERED, SLOT_W'(s), 1'b1};
          end
        end
        fresh_q.push_back(n);
      end
      KIND_REMOVE: begin
        if (id_ok) clear_timer_slot(it.slot_id);
      end
      KIND_ENABLE: begin
        // also legal on a free slot: it then blocks allocation but never fires
        if (id_ok) begin
          tm_en[it.slot_id]    = 1'b1;
          tm_stamp[it.slot_id] = it.now_ms;
        end
      end
      KIND_DISABLE: begin
        if (id_ok) tm_en[it.slot_id] = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic flag_error(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void add_row(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now_ms,
                                  logic [TIME_W-1:0] interval_ms, logic [SLOT_W-1:0] slot_id,
                                  int unsigned reps, bit pinned,
                                  logic [RES_W-1:0] want_kind, logic [SLOT_W-1:0] want_slot);
    walk_row_t row;
    row.item   = '{kind, now_ms, interval_ms, slot_id};
    row.reps   = reps;
    row.pinned = pinned;
    row.want   = '{want_kind, want_slot, 1'b1};
    walk_q.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Holds valid until the transaction goes through, then books its notices.
  // Valid is left high so that a back-to-back item needs no second write.
  task automatic send_item(timer_item_t it, bit pinned, notice_t want);
    in_bus.valid       <= 1'b1;
    in_bus.kind        <= it.kind;
    in_bus.now_ms      <= it.now_ms;
    in_bus.interval_ms <= it.interval_ms;
    in_bus.slot_id     <= it.slot_id;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    apply_timer_item(it);
    if (pinned) notice_q.push_back(want);
    else foreach (fresh_q[i]) notice_q.push_back(fresh_q[i]);
  endtask

  // Bursts of random length, random gaps between them (often none)
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until the block owes nothing. The loop waits on the clock before
  // its first test, so valid never sees a low and a high write in the same step.
  task automatic drain_notices();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (notice_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Output side: sink stalls on a pattern of its own, switching style now
  // and then (always ready, coin toss, rotating comb, long on/off holds).
  // --------------------------------------------------------------------------
  initial begin
    rx_mode_t    mode;
    int unsigned phase_left;
    int unsigned hold;
    logic [7:0]  comb;
    logic        rdy;
    mode       = RX_FLOW;
    phase_left = 0;
    hold       = 0;
    comb       = 8'b1011_0010;
    rdy        = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        mode       = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(50, 300);
      end
      phase_left--;
      comb = {comb[0], comb[7:1]};
      case (mode)
        RX_FLOW: rdy = 1'b1;
        RX_COIN: rdy = 1'($urandom_range(0, 1));
        RX_COMB: rdy = comb[0];
        default: begin
          if (hold == 0) begin
            rdy  = !rdy;
            hold = rdy ? $urandom_range(1, 6) : $urandom_range(1, 20);
          end
          hold--;
        end
      endcase
      out_bus.ready <= rdy;
    end
  end

  // Every output transaction is matched against the oldest notice owed
  notice_t got_want;
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (notice_q.size() == 0) begin
        flag_error($sformatf("result with nothing owed: kind %0d slot %0d last %0b",
                             out_bus.result_kind, out_bus.slot, out_bus.last));
      end else begin
        got_want = notice_q.pop_front();
        if (out_bus.result_kind !== got_want.result_kind)
          flag_error($sformatf("result_kind %0d, want %0d (slot %0d)",
                               out_bus.result_kind, got_want.result_kind, got_want.slot));
        if (out_bus.slot !== got_want.slot)
          flag_error($sformatf("slot %0d, want %0d", out_bus.slot, got_want.slot));
        if (out_bus.last !== got_want.last)
          flag_error($sformatf("last %0b, want %0b (slot %0d)",
                               out_bus.last, got_want.last, got_want.slot));
      end
    end
  end

  // Watchdog: cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d notices owed",
               $realtime, STUCK_LIMIT, notice_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    timer_item_t       it;
    notice_t           none;
    walk_row_t         row;
    logic [TIME_W-1:0] wall_ms;
    int unsigned       live_items;
    int unsigned       r;
    none       = '{RES_FIRED, '0, 1'b0};
    live_items = 0;

    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.kind        <= KIND_SCAN;
    in_bus.now_ms      <= '0;
    in_bus.interval_ms <= '0;
    in_bus.slot_id     <= '0;
    for (int s = 0; s < SLOTS; s++) clear_timer_slot(s);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed walk ----
    // empty table: scan raises nothing; out-of-range ids are dropped
    add_row(KIND_SCAN,         32'd0,         32'd0,         6'd0,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_REMOVE,       32'd0,         32'd0,         6'd63, 1,  0, RES_FIRED, 6'd0);
    add_row(KIND_ENABLE,       32'd123,       32'd0,         6'd16, 1,  0, RES_FIRED, 6'd0);
    add_row(KIND_DISABLE,      32'd0,         32'd0,         6'd32, 1,  0, RES_FIRED, 6'd0);
    // first allocations after reset, at the extremes of time and period
    add_row(KIND_REG_PERIODIC, 32'd0,         32'd0,         6'd0,  1,  1, RES_REGISTERED, 6'd0);
    add_row(KIND_REG_ONCE,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0,  1,  1, RES_REGISTERED, 6'd1);
    // enable on a free slot parks it: skipped by allocation, never fires
    add_row(KIND_ENABLE,       32'd5,         32'd0,         6'd2,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_REG_PERIODIC, 32'd5,         32'd10,        6'd0,  13, 0, RES_FIRED, 6'd0);
    add_row(KIND_REG_ONCE,     32'd6,         32'd0,         6'd0,  1,  1, RES_FULL, 6'd0);
    // scan across the wrap: many slots fire in one go
    add_row(KIND_SCAN,         32'hFFFF_FFFF, 32'd0,         6'd0,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_DISABLE,      32'd0,         32'd0,         6'd0,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_REMOVE,       32'd0,         32'd0,         6'd2,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_REG_ONCE,     32'd7,         32'd0,         6'd0,  1,  1, RES_REGISTERED, 6'd2);
    // one-shot fires and frees itself; max period never fires
    add_row(KIND_SCAN,         32'd8,         32'd0,         6'd0,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_ENABLE,       32'd8,         32'd0,         6'd0,  1,  0, RES_FIRED, 6'd0);
    // elapsed equal to period must not fire; one more ms must
    add_row(KIND_SCAN,         32'd9,         32'd0,         6'd0,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_SCAN,         32'd10,        32'd0,         6'd0,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_SPARE6,       32'd11,        32'd1,         6'd1,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_SPARE7,       32'd11,        32'd1,         6'd1,  1,  0, RES_FIRED, 6'd0);
    add_row(KIND_REMOVE,       32'd0,         32'd0,         6'd15, 1,  0, RES_FIRED, 6'd0);
    add_row(KIND_REG_PERIODIC, 32'h8000_0000, 32'd1,         6'd0,  1,  1, RES_REGISTERED, 6'd2);

    foreach (walk_q[i]) begin
      row = walk_q[i];
      repeat (row.reps) begin
        send_item(row.item, row.pinned, row.pinned ? row.want : none);
        pace_sender();
      end
    end
    drain_notices();

    // ---- random traffic ----
    wall_ms = $urandom();
    while (live_items < LIVE_ITEMS) begin
      // time mostly creeps forward; now and then it jumps anywhere
      if ($urandom_range(0, 19) == 0) wall_ms = $urandom();
      else wall_ms = wall_ms + $urandom_range(0, 40);
      it.now_ms = wall_ms;

      r = $urandom_range(0, 99);
      if (r < 34)      it.kind = KIND_SCAN;
      else if (r < 48) it.kind = KIND_REG_PERIODIC;
      else if (r < 60) it.kind = KIND_REG_ONCE;
      else if (r < 72) it.kind = KIND_REMOVE;
      else if (r < 84) it.kind = KIND_ENABLE;
      else if (r < 96) it.kind = KIND_DISABLE;
      else             it.kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;

      r = $urandom_range(0, 9);
      if (r < 7)       it.interval_ms = $urandom_range(0, 60);
      else if (r == 7) it.interval_ms = '0;
      else if (r == 8) it.interval_ms = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else             it.interval_ms = $urandom();

      it.slot_id = SLOT_W'(($urandom_range(0, 99) < 88) ? $urandom_range(0, SLOTS - 1)
                                                        : $urandom_range(SLOTS, 63));

      send_item(it, 1'b0, none);
      live_items++;

      if (live_items % 70 == 69) drain_notices();
      else pace_sender();
    end

    // ---- wind down ----
    drain_notices();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (notice_q.size() != 0)
      flag_error($sformatf("%0d notices never delivered", notice_q.size()));

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
